/* design/pca_pkg.sv */
`timescale 1ns / 1ps

package pca_pkg;

	localparam int DW  = 32;            // value width, signed Q16.16
	localparam int GW  = 24;            // gain width, unsigned Q8.16
	localparam int PW  = DW + GW + 1;   // full product width
	localparam int FW  = 16;            // fraction bits of a gain
	localparam int DDW = 17;            // width of d
	localparam int UW  = 31;            // width of umax
	localparam int SW  = 4;             // step counter width
	localparam int AW  = 5;             // APB address width
	localparam int CW  = 32;            // APB data width

	localparam logic [DDW-1:0] D_ONE = DDW'(65536);

	typedef logic signed [DW-1:0] val_t;
	typedef logic signed [PW-1:0] prod_t;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_KP,
		REG_IKS,
		REG_D,
		REG_UMAX
	} reg_t;

	typedef struct packed {
		logic           mode;
		logic [GW-1:0]  kp;
		logic [GW-1:0]  inv_ks;
		logic [DDW-1:0] d;
		logic [UW-1:0]  umax;
	} cfg_t;

	typedef enum logic [2:0] {ASEL_REF, ASEL_LC, ASEL_LE, ASEL_E, ASEL_ZERO} asel_t;
	typedef enum logic [1:0] {BSEL_FB, BSEL_LR, BSEL_RND} bsel_t;
	typedef enum logic [1:0] {DST_NONE, DST_E, DST_T} dst_t;
	typedef enum logic       {MSEL_T, MSEL_E} msel_t;
	typedef enum logic [1:0] {GSEL_KP, GSEL_IKS, GSEL_D} gsel_t;

	// one microcode word
	typedef struct packed {
		asel_t          asel;
		bsel_t          bsel;
		logic           sub;
		dst_t           dst;
		logic           mul;
		msel_t          msel;
		gsel_t          gsel;
		logic           fin;
		logic           jmp_p;    // jump when in proportional mode
		logic           jmp;
		logic [SW-1:0]  target;
	} ucw_t;

	typedef struct packed {
		ucw_t cw;
		logic go;
	} ctl_t;

	localparam logic [SW-1:0] ST_CLAMP = SW'(8);
	localparam logic [SW-1:0] ST_PROP  = SW'(9);

	// microprogram: PI path is steps 0..8, proportional path 0, 9, 10, 8
	function automatic ucw_t ucode(input logic [SW-1:0] step);
		ucw_t w;
		w = '0;
		w.asel = ASEL_ZERO;
		w.bsel = BSEL_RND;
		w.dst  = DST_NONE;
		w.msel = MSEL_T;
		w.gsel = GSEL_KP;
		unique case (step)
			SW'(0): begin
				w.asel = ASEL_REF; w.bsel = BSEL_FB; w.sub = 1'b1; w.dst = DST_E;
				w.jmp_p = 1'b1; w.target = ST_PROP;
			end
			SW'(1): begin
				w.asel = ASEL_LC; w.bsel = BSEL_LR; w.sub = 1'b1; w.dst = DST_T;
			end
			SW'(2): begin
				w.mul = 1'b1; w.msel = MSEL_T; w.gsel = GSEL_IKS;
			end
			SW'(3): begin
				w.asel = ASEL_LE; w.bsel = BSEL_RND; w.dst = DST_T;
			end
			SW'(4): begin
				w.mul = 1'b1; w.msel = MSEL_T; w.gsel = GSEL_D;
			end
			SW'(5): begin
				w.asel = ASEL_E; w.bsel = BSEL_RND; w.sub = 1'b1; w.dst = DST_T;
			end
			SW'(6): begin
				w.mul = 1'b1; w.msel = MSEL_T; w.gsel = GSEL_KP;
			end
			SW'(7): begin
				w.asel = ASEL_LC; w.bsel = BSEL_RND; w.dst = DST_T;
			end
			ST_CLAMP: begin
				w.fin = 1'b1;
			end
			ST_PROP: begin
				w.mul = 1'b1; w.msel = MSEL_E; w.gsel = GSEL_KP;
			end
			SW'(10): begin
				w.asel = ASEL_ZERO; w.bsel = BSEL_RND; w.dst = DST_T;
				w.jmp = 1'b1; w.target = ST_CLAMP;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

	// saturate a one-bit-grown sum to DW bits
	function automatic val_t sat_sum(input logic signed [DW:0] x);
		val_t r;
		if (x[DW] != x[DW-1])
			r = x[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		else
			r = x[DW-1:0];
		return r;
	endfunction

	// round the gain product to nearest (ties up), drop fraction, saturate
	function automatic val_t rnd_prod(input prod_t p);
		prod_t                   r;
		logic signed [PW-FW-1:0] s;
		val_t                    o;
		r = p + PW'(1 << (FW - 1));
		s = r[PW-1:FW];
		if ((&s[PW-FW-1:DW-1]) || !(|s[PW-FW-1:DW-1]))
			o = s[DW-1:0];
		else
			o = s[PW-FW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		return o;
	endfunction

endpackage

/* design/pca_cfg.sv */
`timescale 1ns / 1ps

module pca_cfg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [pca_pkg::AW-1:0]  paddr,
	input  logic [pca_pkg::CW-1:0]  pwdata,
	output logic [pca_pkg::CW-1:0]  prdata,
	output logic                    pready,
	output pca_pkg::cfg_t           cfg
);

	pca_pkg::cfg_t cfg_q;
	pca_pkg::reg_t idx;
	logic          wr;
	logic [pca_pkg::DDW-1:0] d_in;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = pca_pkg::reg_t'(paddr[pca_pkg::AW-1:2]);
	assign d_in   = pwdata[pca_pkg::DDW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= 1'b0;
			cfg_q.kp     <= pca_pkg::GW'(65536);
			cfg_q.inv_ks <= pca_pkg::GW'(65536);
			cfg_q.d      <= '0;
			cfg_q.umax   <= pca_pkg::UW'(65536);
		end else if (wr) begin
			case (idx)
				pca_pkg::REG_MODE: cfg_q.mode   <= pwdata[0];
				pca_pkg::REG_KP:   cfg_q.kp     <= pwdata[pca_pkg::GW-1:0];
				pca_pkg::REG_IKS:  cfg_q.inv_ks <= pwdata[pca_pkg::GW-1:0];
				pca_pkg::REG_D:    cfg_q.d      <= (d_in > pca_pkg::D_ONE) ? pca_pkg::D_ONE : d_in;
				pca_pkg::REG_UMAX: cfg_q.umax   <= pwdata[pca_pkg::UW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			pca_pkg::REG_MODE: prdata = pca_pkg::CW'(cfg_q.mode);
			pca_pkg::REG_KP:   prdata = pca_pkg::CW'(cfg_q.kp);
			pca_pkg::REG_IKS:  prdata = pca_pkg::CW'(cfg_q.inv_ks);
			pca_pkg::REG_D:    prdata = pca_pkg::CW'(cfg_q.d);
			pca_pkg::REG_UMAX: prdata = pca_pkg::CW'(cfg_q.umax);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* design/pca_seq.sv */
`timescale 1ns / 1ps

module pca_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          mode,
	input  logic          hold,
	output pca_pkg::ctl_t ctl,
	output logic          busy
);

	logic [pca_pkg::SW-1:0] step_q;
	logic                   busy_q;
	pca_pkg::ucw_t          cw;
	logic                   go;

	assign cw = pca_pkg::ucode(step_q);
	// the final step waits while the output register is still full and out_stall is high
	assign go = busy_q && !(cw.fin && hold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (go) begin
			if (cw.fin)
				busy_q <= 1'b0;
			else if (cw.jmp || (cw.jmp_p && !mode))
				step_q <= cw.target;
			else
				step_q <= step_q + 1'b1;
		end
	end

	assign ctl.cw = cw;
	assign ctl.go = go;
	assign busy   = busy_q;

endmodule

/* design/pca_dpath.sv */
`timescale 1ns / 1ps

module pca_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  pca_pkg::ctl_t       ctl,
	input  pca_pkg::cfg_t       cfg,
	input  logic                load,
	input  pca_pkg::val_t       ref_req,
	input  pca_pkg::val_t       fb,
	input  logic                out_stall,
	output pca_pkg::val_t       drive,
	output logic                clamped,
	output logic                out_valid,
	output logic                hold
);

	pca_pkg::val_t  ref_q, fb_q, e_q, t_q;
	pca_pkg::prod_t p_q;
	pca_pkg::val_t  le_q, lr_q, lc_q;
	pca_pkg::val_t  drive_q;
	logic           clamped_q, out_valid_q;

	pca_pkg::val_t  a_op, b_op, rnd, res, m_op;
	logic signed [pca_pkg::DW:0] sum;
	logic signed [pca_pkg::GW:0] g_op;
	pca_pkg::prod_t p_c;
	pca_pkg::val_t  lim, nlim, us;
	logic           flag;

	assign rnd = pca_pkg::rnd_prod(p_q);

	always_comb begin
		unique case (ctl.cw.asel)
			pca_pkg::ASEL_REF:  a_op = ref_q;
			pca_pkg::ASEL_LC:   a_op = lc_q;
			pca_pkg::ASEL_LE:   a_op = le_q;
			pca_pkg::ASEL_E:    a_op = e_q;
			default:            a_op = '0;
		endcase
		unique case (ctl.cw.bsel)
			pca_pkg::BSEL_FB:   b_op = fb_q;
			pca_pkg::BSEL_LR:   b_op = lr_q;
			default:            b_op = rnd;
		endcase
	end

	assign sum = ctl.cw.sub ? ({a_op[pca_pkg::DW-1], a_op} - {b_op[pca_pkg::DW-1], b_op})
	                        : ({a_op[pca_pkg::DW-1], a_op} + {b_op[pca_pkg::DW-1], b_op});
	assign res = pca_pkg::sat_sum(sum);

	always_comb begin
		m_op = (ctl.cw.msel == pca_pkg::MSEL_E) ? e_q : t_q;
		unique case (ctl.cw.gsel)
			pca_pkg::GSEL_KP:  g_op = {1'b0, cfg.kp};
			pca_pkg::GSEL_IKS: g_op = {1'b0, cfg.inv_ks};
			default:           g_op = {1'b0, pca_pkg::GW'(cfg.d)};
		endcase
	end

	assign p_c = m_op * g_op;

	// clamp against +/-umax
	assign lim  = {1'b0, cfg.umax};
	assign nlim = -lim;
	always_comb begin
		flag = 1'b1;
		if (t_q > lim)
			us = lim;
		else if (t_q < nlim)
			us = nlim;
		else begin
			us   = t_q;
			flag = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ref_q <= ref_req;
			fb_q  <= fb;
		end
		if (ctl.go && ctl.cw.dst == pca_pkg::DST_E)
			e_q <= res;
		if (ctl.go && ctl.cw.dst == pca_pkg::DST_T)
			t_q <= res;
		if (ctl.go && ctl.cw.mul)
			p_q <= p_c;
		if (ctl.go && ctl.cw.fin) begin
			drive_q   <= us;
			clamped_q <= flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q        <= '0;
			lr_q        <= '0;
			lc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.go && ctl.cw.fin) begin
				out_valid_q <= 1'b1;
				if (cfg.mode) begin
					le_q <= e_q;
					lr_q <= t_q;
					lc_q <= us;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign drive     = drive_q;
	assign clamped   = clamped_q;
	assign out_valid = out_valid_q;
	assign hold      = out_valid_q && out_stall;

endmodule

/* design/pi_controller_antiwindup.sv */
`timescale 1ns / 1ps

// Velocity-form PI controller with back-calculation anti-windup.
// Input channel: in_valid / in_stall carry one beat of ref_req and fb
// (signed Q16.16). Output channel: out_valid / out_stall carry one beat of
// drive (signed Q16.16) and clamped. Gains and limits sit in APB registers:
// 0x00 mode, 0x04 kp, 0x08 inv_ks, 0x0C d, 0x10 umax; write them only while idle.
// A small microprogram steps one shared adder and one 32x25 multiplier.
// In PI mode an item runs three dependent gain multiplies, each followed
// by a rounding add or subtract, then the clamp; in proportional mode it
// runs one kp multiply, a rounding add and the clamp. The next input beat
// is taken the cycle after the result is loaded; items do not overlap.
// in_stall is high while an item is in work.
// The result sits in an output register; while out_stall holds it, a new
// item is still accepted and computed, and waits at its clamp step until the
// register frees up.
// Reset zeroes the stored last error, raw drive and clamped drive and loads the
// register defaults: proportional mode, kp = inv_ks = 1.0, d = 0, umax = 1.0.
module pi_controller_antiwindup (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [31:0]      ref_req,
	input  logic signed [31:0]      fb,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      drive,
	output logic                    clamped,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [pca_pkg::AW-1:0]  paddr,
	input  logic [pca_pkg::CW-1:0]  pwdata,
	output logic [pca_pkg::CW-1:0]  prdata,
	output logic                    pready
);

	pca_pkg::cfg_t cfg;
	pca_pkg::ctl_t ctl;
	logic          busy, hold, start;

	assign in_stall = busy;
	assign start    = in_valid && !busy;

	pca_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pca_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (cfg.mode),
		.hold   (hold),
		.ctl    (ctl),
		.busy   (busy)
	);

	pca_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cfg       (cfg),
		.load      (start),
		.ref_req   (ref_req),
		.fb        (fb),
		.out_stall (out_stall),
		.drive     (drive),
		.clamped   (clamped),
		.out_valid (out_valid),
		.hold      (hold)
	);

endmodule
